>>> rtl/rftp_pkg.sv
// Package for the raft follower progress tracker.
// Holds the event and mode codes, the index width and the record and flag types.
// Depends on nothing.
package rftp_pkg;

  localparam int unsigned IndexW = 64;
  localparam int unsigned KindW  = 4;
  localparam int unsigned ModeW  = 2;

  typedef enum logic [KindW-1:0] {
    KIND_RETRY      = 4'd0,
    KIND_WAIT       = 4'd1,
    KIND_REPLICATE  = 4'd2,
    KIND_SNAPSHOT   = 4'd3,
    KIND_CLEAR_SNAP = 4'd4,
    KIND_TRY_UPDATE = 4'd5,
    KIND_PROGRESS   = 4'd6,
    KIND_RESPONDED  = 4'd7,
    KIND_DECREASE   = 4'd8,
    KIND_SET_ACTIVE = 4'd9
  } kind_e;

  typedef enum logic [ModeW-1:0] {
    MODE_RETRY     = 2'd0,
    MODE_WAIT      = 2'd1,
    MODE_REPLICATE = 2'd2,
    MODE_SNAPSHOT  = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [IndexW-1:0]  match_idx;
    logic [IndexW-1:0]  next_idx;
    logic [IndexW-1:0]  snap_idx;
    logic               active;
  } rftp_state_t;

  typedef struct packed {
    logic accepted;
    logic bad_state;
  } rftp_flags_t;

endpackage

>>> rtl/rftp_update.sv
// Next-state logic of the raft follower progress tracker for one event.
// Purely combinational; uses the types and codes of rftp_pkg.
module rftp_update (
  input  rftp_pkg::rftp_state_t       state_i,
  input  logic [rftp_pkg::KindW-1:0]  kind_i,
  input  logic [rftp_pkg::IndexW-1:0] index_value_i,
  input  logic [rftp_pkg::IndexW-1:0] limit_index_i,
  input  logic                        active_value_i,
  output rftp_pkg::rftp_state_t       state_o,
  output rftp_pkg::rftp_flags_t       flags_o
);
  import rftp_pkg::*;

  localparam logic [IndexW-1:0] One = IndexW'(1);

  logic [IndexW-1:0] match_inc;
  logic [IndexW-1:0] snap_inc;
  logic [IndexW-1:0] index_inc;
  logic [IndexW-1:0] limit_inc;
  logic [IndexW-1:0] next_dec;
  logic [IndexW-1:0] retry_next;
  logic [IndexW-1:0] clamp_low;
  logic [IndexW-1:0] clamp_next;

  assign match_inc  = state_i.match_idx + One;
  assign snap_inc   = state_i.snap_idx + One;
  assign index_inc  = index_value_i + One;
  assign limit_inc  = limit_index_i + One;
  assign next_dec   = state_i.next_idx - One;
  assign retry_next = (state_i.mode == MODE_SNAPSHOT && snap_inc > match_inc) ?
                      snap_inc : match_inc;
  assign clamp_low  = (index_value_i < limit_inc) ? index_value_i : limit_inc;
  assign clamp_next = (clamp_low > One) ? clamp_low : One;

  always_comb begin
    state_o = state_i;
    flags_o = '0;
    case (kind_e'(kind_i))
      KIND_RETRY, KIND_WAIT: begin
        state_o.next_idx = retry_next;
        state_o.snap_idx = '0;
        state_o.mode     = (kind_e'(kind_i) == KIND_WAIT) ? MODE_WAIT : MODE_RETRY;
      end
      KIND_REPLICATE: begin
        state_o.next_idx = match_inc;
        state_o.snap_idx = '0;
        state_o.mode     = MODE_REPLICATE;
      end
      KIND_SNAPSHOT: begin
        state_o.snap_idx = index_value_i;
        state_o.mode     = MODE_SNAPSHOT;
      end
      KIND_CLEAR_SNAP: begin
        state_o.snap_idx = '0;
      end
      KIND_TRY_UPDATE: begin
        if (state_i.next_idx < index_inc) begin
          state_o.next_idx = index_inc;
        end
        if (state_i.match_idx < index_value_i) begin
          if (state_i.mode == MODE_WAIT) begin
            state_o.mode = MODE_RETRY;
          end
          state_o.match_idx = index_value_i;
          flags_o.accepted  = 1'b1;
        end
      end
      KIND_PROGRESS: begin
        if (state_i.mode == MODE_REPLICATE) begin
          state_o.next_idx = index_inc;
        end else if (state_i.mode == MODE_RETRY) begin
          state_o.mode = MODE_WAIT;
        end else begin
          flags_o.bad_state = 1'b1;
        end
      end
      KIND_RESPONDED: begin
        if (state_i.mode == MODE_RETRY) begin
          state_o.next_idx = match_inc;
          state_o.snap_idx = '0;
          state_o.mode     = MODE_REPLICATE;
        end else if (state_i.mode == MODE_SNAPSHOT &&
                     state_i.match_idx >= state_i.snap_idx) begin
          state_o.next_idx = retry_next;
          state_o.snap_idx = '0;
          state_o.mode     = MODE_RETRY;
        end
      end
      KIND_DECREASE: begin
        if (state_i.mode == MODE_REPLICATE) begin
          if (index_value_i > state_i.match_idx) begin
            state_o.next_idx = match_inc;
            flags_o.accepted = 1'b1;
          end
        end else if (next_dec == index_value_i) begin
          if (state_i.mode == MODE_WAIT) begin
            state_o.mode = MODE_RETRY;
          end
          state_o.next_idx = clamp_next;
          flags_o.accepted = 1'b1;
        end
      end
      KIND_SET_ACTIVE: begin
        state_o.active = active_value_i;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/raft_follower_progress_tracker_core.sv
// Top level of the raft follower progress tracker.
// Holds the input register, the follower record and the result flags; uses rftp_pkg
// and rftp_update.
//
// One event is accepted per cycle unless a stalled result blocks the input. An accepted
// event is registered in the input register; rftp_update then applies it to the
// follower record, and the new record and flags are registered in the result stage and
// shown on the output. The record registers double as the result payload. A new event
// is taken whenever the input register is empty or its event moves into the result
// stage, which happens when the result stage is empty or its result is taken.
module raft_follower_progress_tracker_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rftp_pkg::KindW-1:0]  kind_i,
  input  logic [rftp_pkg::IndexW-1:0] index_value_i,
  input  logic [rftp_pkg::IndexW-1:0] limit_index_i,
  input  logic                        active_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        accepted_o,
  output logic                        bad_state_o,
  output logic                        paused_o,
  output logic                        active_now_o,
  output logic [rftp_pkg::ModeW-1:0]  mode_now_o,
  output logic [rftp_pkg::IndexW-1:0] next_now_o,
  output logic [rftp_pkg::IndexW-1:0] match_now_o,
  output logic [rftp_pkg::IndexW-1:0] snapshot_now_o
);
  import rftp_pkg::*;

  logic              in_valid_q;
  logic [KindW-1:0]  kind_q;
  logic [IndexW-1:0] index_q;
  logic [IndexW-1:0] limit_q;
  logic              active_q;
  logic              out_valid_q;
  logic              advance;
  rftp_state_t       state_q;
  rftp_state_t       state_d;
  rftp_flags_t       flags_q;
  rftp_flags_t       flags_d;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  rftp_update u_update (
    .state_i        (state_q),
    .kind_i         (kind_q),
    .index_value_i  (index_q),
    .limit_index_i  (limit_q),
    .active_value_i (active_q),
    .state_o        (state_d),
    .flags_o        (flags_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q         <= 1'b0;
      out_valid_q        <= 1'b0;
      state_q.mode       <= MODE_RETRY;
      state_q.match_idx  <= '0;
      state_q.next_idx   <= IndexW'(1);
      state_q.snap_idx   <= '0;
      state_q.active     <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      kind_q   <= kind_i;
      index_q  <= index_value_i;
      limit_q  <= limit_index_i;
      active_q <= active_value_i;
    end
    if (advance) begin
      flags_q <= flags_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = flags_q.accepted;
  assign bad_state_o    = flags_q.bad_state;
  assign paused_o       = (state_q.mode == MODE_WAIT) || (state_q.mode == MODE_SNAPSHOT);
  assign active_now_o   = state_q.active;
  assign mode_now_o     = state_q.mode;
  assign next_now_o     = state_q.next_idx;
  assign match_now_o    = state_q.match_idx;
  assign snapshot_now_o = state_q.snap_idx;

endmodule

>>> rtl/rftp_checker.sv
// Port-level checker for the raft follower progress tracker, bound to the top level.
// Uses the mode codes of rftp_pkg.
module rftp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        accepted_o,
  input logic                        bad_state_o,
  input logic                        paused_o,
  input logic [rftp_pkg::ModeW-1:0]  mode_now_o,
  input logic [rftp_pkg::IndexW-1:0] next_now_o,
  input logic [rftp_pkg::IndexW-1:0] match_now_o
);
  import rftp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(next_now_o) &&
    $stable(match_now_o) && $stable(mode_now_o))
    else $error("Stalled result changed.");

  a_paused_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> paused_o == (mode_now_o == MODE_WAIT || mode_now_o == MODE_SNAPSHOT))
    else $error("Paused flag disagrees with the mode.");

  a_bad_not_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_state_o |-> !accepted_o && paused_o)
    else $error("Bad state reported with acceptance or outside a paused mode.");

  a_match_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i ##1 out_valid_o |-> match_now_o >= $past(match_now_o))
    else $error("Match index went backward.");

endmodule

bind raft_follower_progress_tracker_core rftp_checker u_rftp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .accepted_o  (accepted_o),
  .bad_state_o (bad_state_o),
  .paused_o    (paused_o),
  .mode_now_o  (mode_now_o),
  .next_now_o  (next_now_o),
  .match_now_o (match_now_o)
);
